>>> src/tfbm_pkg.sv
// ============================================================================
// tfbm_pkg
// Shared types and codes for the triple frame buffer manager.
// ============================================================================
package tfbm_pkg;

    // command codes
    localparam logic [1:0] CMD_COMPLETE = 2'd0;
    localparam logic [1:0] CMD_ACQUIRE  = 2'd1;
    localparam logic [1:0] CMD_RELEASE  = 2'd2;

    // buffer ownership codes
    localparam logic [1:0] OWN_FREE    = 2'd0;
    localparam logic [1:0] OWN_FILLING = 2'd1;
    localparam logic [1:0] OWN_READY   = 2'd2;
    localparam logic [1:0] OWN_IN_USE  = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] buf_idx;
    } request_t;

    typedef struct packed {
        logic        success;
        logic [2:0]  chosen_buffer;
        logic [31:0] frame_sequence;
        logic        replaced_stale;
        logic [31:0] total_frames;
        logic [31:0] stale_total;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;       // latch the request beat, clear scan state
        logic mark_done;     // stamp the filling buffer and mark it ready
        logic pick_free;     // hand the lowest free buffer to the writer
        logic scan_step;     // examine one buffer for oldest / newest ready
        logic finish_scan;   // apply the scan winner
        logic finish_simple; // release or unused command
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic free_found;
        logic scan_last;
    } stat_t;

endpackage

>>> src/tfbm_ctrl.sv
// ============================================================================
// tfbm_ctrl
// Command sequencer: decodes each accepted beat and steps the datapath.
// ============================================================================
module tfbm_ctrl
    import tfbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  stat_t      stat,
    output logic       busy,
    output ctrl_t      ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MARK   = 3'd1;
    localparam logic [2:0] S_PICK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_SIMPLE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.capture = 1'b1;
                    case (command)
                        CMD_COMPLETE: state_next = S_MARK;
                        CMD_ACQUIRE:  state_next = S_SCAN;
                        default:      state_next = S_SIMPLE;
                    endcase
                end
            end
            S_MARK:
            begin
                ctrl.mark_done = 1'b1;
                state_next     = S_PICK;
            end
            S_PICK:
            begin
                if (stat.free_found)
                begin
                    ctrl.pick_free = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctrl.finish_scan = 1'b1;
                state_next       = S_IDLE;
            end
            S_SIMPLE:
            begin
                ctrl.finish_simple = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/tfbm_dpath.sv
// ============================================================================
// tfbm_dpath
// Buffer ownership table, sequence stamps, counters, scan unit and result
// register.
// ============================================================================
module tfbm_dpath
    import tfbm_pkg::*;
#(
    parameter int BUFFER_COUNT = 3
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  request_t request,
    input  ctrl_t    ctrl,
    output stat_t    stat,
    output logic     done,
    output result_t  result
);

    localparam int IDX_W = $clog2(BUFFER_COUNT);

    logic [1:0]       cmd_reg;
    logic [2:0]       idx_reg;
    logic [1:0]       own_reg  [BUFFER_COUNT];
    logic [1:0]       own_next [BUFFER_COUNT];
    logic [31:0]      fn_reg   [BUFFER_COUNT];
    logic [31:0]      fn_next  [BUFFER_COUNT];
    logic [IDX_W-1:0] fill_reg,     fill_next;
    logic [31:0]      total_reg,    total_next;
    logic [31:0]      stale_reg,    stale_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] best_reg,     best_next;
    logic [31:0]      best_seq_reg, best_seq_next;
    logic             found_reg,    found_next;
    result_t          res_reg,      res_next;
    logic             done_reg,     done_next;

    logic [BUFFER_COUNT-1:0] is_free;
    logic [BUFFER_COUNT-1:0] is_ready;
    logic [BUFFER_COUNT-1:0] is_in_use;
    logic [7:0]              in_use_pad;
    logic [IDX_W-1:0]        free_idx;
    logic [31:0]             scan_seq;
    logic                    oldest_mode;
    logic                    better;
    logic                    release_ok;

    always_comb
    begin
        for (int i = 0; i < BUFFER_COUNT; i++)
        begin
            is_free[i]   = (own_reg[i] == OWN_FREE);
            is_ready[i]  = (own_reg[i] == OWN_READY);
            is_in_use[i] = (own_reg[i] == OWN_IN_USE);
        end
    end

    assign in_use_pad = 8'(is_in_use);

    // lowest-index free buffer
    always_comb
    begin
        free_idx = '0;
        for (int i = BUFFER_COUNT - 1; i >= 0; i--)
        begin
            if (is_free[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign stat.free_found = |is_free;
    assign stat.scan_last  = (scan_idx_reg == IDX_W'(BUFFER_COUNT - 1));

    // completion scans for oldest (strict <, lowest index wins ties),
    // acquire scans for newest (>=, highest index wins ties)
    assign oldest_mode = (cmd_reg == CMD_COMPLETE);
    assign scan_seq    = fn_reg[scan_idx_reg];
    assign better      = !found_reg ||
                         (oldest_mode ? (scan_seq < best_seq_reg)
                                      : (scan_seq >= best_seq_reg));
    assign release_ok  = (cmd_reg == CMD_RELEASE) &&
                         (4'(idx_reg) < 4'(BUFFER_COUNT)) && in_use_pad[idx_reg];

    always_comb
    begin
        own_next      = own_reg;
        fn_next       = fn_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        stale_next    = stale_reg;
        scan_idx_next = scan_idx_reg;
        best_next     = best_reg;
        best_seq_next = best_seq_reg;
        found_next    = found_reg;
        res_next      = res_reg;
        done_next     = 1'b0;

        if (ctrl.capture)
        begin
            scan_idx_next = '0;
            best_next     = '0;
            best_seq_next = '0;
            found_next    = 1'b0;
        end

        if (ctrl.mark_done)
        begin
            total_next        = total_reg + 32'd1;
            fn_next[fill_reg]  = total_reg + 32'd1;
            own_next[fill_reg] = OWN_READY;
        end

        if (ctrl.pick_free)
        begin
            own_next[free_idx]      = OWN_FILLING;
            fill_next               = free_idx;
            res_next.success        = 1'b1;
            res_next.chosen_buffer  = 3'(free_idx);
            res_next.frame_sequence = total_reg;
            res_next.replaced_stale = 1'b0;
            res_next.total_frames   = total_reg;
            res_next.stale_total    = stale_reg;
            done_next               = 1'b1;
        end

        if (ctrl.scan_step)
        begin
            if (is_ready[scan_idx_reg] && better)
            begin
                best_next     = scan_idx_reg;
                best_seq_next = scan_seq;
                found_next    = 1'b1;
            end
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        if (ctrl.finish_scan)
        begin
            done_next             = 1'b1;
            res_next              = '0;
            res_next.total_frames = total_reg;
            res_next.stale_total  = stale_reg;
            if (oldest_mode)
            begin
                // the buffer just stamped is always ready, so found is set
                stale_next              = stale_reg + 32'd1;
                own_next[best_reg]      = OWN_FILLING;
                fill_next               = best_reg;
                res_next.success        = 1'b1;
                res_next.chosen_buffer  = 3'(best_reg);
                res_next.frame_sequence = total_reg;
                res_next.replaced_stale = 1'b1;
                res_next.stale_total    = stale_reg + 32'd1;
            end
            else if (found_reg)
            begin
                own_next[best_reg]      = OWN_IN_USE;
                res_next.success        = 1'b1;
                res_next.chosen_buffer  = 3'(best_reg);
                res_next.frame_sequence = best_seq_reg;
            end
        end

        if (ctrl.finish_simple)
        begin
            done_next             = 1'b1;
            res_next              = '0;
            res_next.total_frames = total_reg;
            res_next.stale_total  = stale_reg;
            if (release_ok)
            begin
                for (int i = 0; i < BUFFER_COUNT; i++)
                begin
                    if (3'(i) == idx_reg)
                    begin
                        own_next[i] = OWN_FREE;
                    end
                end
                res_next.success = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUFFER_COUNT; i++)
            begin
                own_reg[i] <= (i == 0) ? OWN_FILLING : OWN_FREE;
                fn_reg[i]  <= '0;
            end
            fill_reg  <= '0;
            total_reg <= '0;
            stale_reg <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            own_reg   <= own_next;
            fn_reg    <= fn_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            stale_reg <= stale_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= request.command;
            idx_reg <= request.buf_idx;
        end
        scan_idx_reg <= scan_idx_next;
        best_reg     <= best_next;
        best_seq_reg <= best_seq_next;
        res_reg      <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> src/triple_frame_buffer_manager.sv
// ============================================================================
// triple_frame_buffer_manager
// Frame buffer ownership manager with drop-oldest triple buffering.
// ============================================================================
// Usage:
//   A command beat (request) is taken at a rising edge with start high and
//   busy low. Commands: frame complete, acquire newest ready, release buffer.
//   Each command yields one result beat on result, marked by done for
//   exactly one cycle; the receiver cannot stall, so it must take it then.
//   Sequencer steps from the accept edge to the result beat:
//     release / unused command   finish state, then the result
//     frame complete, free found mark the filling buffer ready, pick the lowest free one
//     acquire                    scan every buffer, then take the newest ready one
//     frame complete, stale      mark, find none free, scan, reuse the oldest ready
//   busy drops as the result appears, so a new command can be taken in the
//   same cycle the result is shown. The oldest/newest ready search steps
//   through the buffers one per cycle with a single 32-bit compare.
//   Reset: buffer 0 filling, others free, all stamps and counters zero.
// ============================================================================
module triple_frame_buffer_manager
    import tfbm_pkg::*;
#(
    parameter int BUFFER_COUNT = 3
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    ctrl_t ctrl;
    stat_t stat;

    tfbm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (request.command),
        .stat    (stat),
        .busy    (busy),
        .ctrl    (ctrl)
    );

    tfbm_dpath #(
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctrl    (ctrl),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

`ifndef SYNTH
    // an accepted beat always occupies the sequencer for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // no command finishes in the cycle it is accepted, so results never abut
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result beats");

    // a stale replacement only comes from a completion
    a_stale_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.replaced_stale) |->
            (result.success && result.frame_sequence == result.total_frames))
        else $error("stale flag on a non-completion result");
`endif

endmodule
